// ----- rtl/core/annealing_acceptance_unit_macros.svh -----
// Assertion macros shared by the annealing acceptance unit.
// Every assertion samples on the rising edge of clk and is off while rst_n is low.
`ifndef ANNEALING_ACCEPTANCE_UNIT_MACROS_SVH
`define ANNEALING_ACCEPTANCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define AAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AAU_NEVER(lbl, cond, msg) \
    `AAU_ASSERT(lbl, !(cond), msg)
`else
`define AAU_ASSERT(lbl, prop, msg)
`define AAU_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/core/aau_pkg.sv -----
package aau_pkg;

    // Default widths of the error and random fields.
    localparam int ERROR_BITS_DEF  = 32;
    localparam int RANDOM_BITS_DEF = 16;

    // Configuration port.
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BREAK_THRESHOLD   = 2'd0,
        CFG_START_TEMPERATURE = 2'd1,
        CFG_COOLING_FACTOR    = 2'd2,
        CFG_ITERATION_LIMIT   = 2'd3
    } cfg_index_t;

    // Register reset values.
    localparam logic [31:0] THRESHOLD_RESET = 32'd655;
    localparam logic [31:0] TSTART_RESET    = 32'd65536;
    localparam logic [15:0] COOL_RESET      = 16'd65470;
    localparam logic [15:0] LIMIT_RESET     = 16'd5000;

    // Operation codes carried in tuser.
    localparam logic OP_START     = 1'b0;
    localparam logic OP_CANDIDATE = 1'b1;

    // Fixed-point layout of the acceptance probability.
    localparam int COOL_BITS   = 16;
    localparam int COUNT_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int INT_BITS    = 4;
    localparam int X_BITS      = FRAC_BITS + INT_BITS;
    localparam int FEED_BITS   = 17;
    localparam int TERM_BITS   = 33;
    localparam int NUM_BITS    = 32;
    localparam int SUM_BITS    = 34;
    localparam int P_BITS      = 17;
    localparam int RECIP_BITS  = 49;
    localparam int N_BITS      = 4;
    localparam int SDIV_BITS   = 8;
    localparam int EXP_SHIFT   = 32;

    localparam logic [TERM_BITS-1:0]  TERM_ONE     = {1'b1, 32'b0};
    localparam logic [RECIP_BITS-1:0] RECIP_ONE    = {1'b1, 48'b0};
    localparam logic [31:0]           EXP_M1_Q32   = 32'd1580030169;
    localparam logic [31:0]           ROUND_HALF   = 32'h8000_0000;
    localparam logic [N_BITS-1:0]     TAYLOR_TERMS = 4'd12;

    // Step counts of the serial units.
    localparam int STEP_BITS   = 5;
    localparam int DIVX_STEPS  = X_BITS;
    localparam int RECIP_STEPS = P_BITS;
    localparam int SDIV_STEPS  = NUM_BITS / SDIV_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVX,
        ST_TINIT,
        ST_TMUL,
        ST_TDIV,
        ST_RPREP,
        ST_RDIV,
        ST_PLOAD,
        ST_SCALE,
        ST_DECIDE,
        ST_COMMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prep_x;
        logic div_step;
        logic tay_init;
        logic tay_mul;
        logic sdiv_step;
        logic sdiv_last;
        logic prep_recip;
        logic p_load;
        logic scale_step;
        logic decide;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_start;
        logic done;
        logic downhill;
        logic k_big;
        logic term_last;
        logic k_zero;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- rtl/core/aau_ctrl.sv -----
`include "annealing_acceptance_unit_macros.svh"

module aau_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  aau_pkg::ctrl_sts_t sts,
    output aau_pkg::ctrl_cmd_t cmd
);

    localparam logic [aau_pkg::STEP_BITS-1:0] DIVX_LAST  =
        aau_pkg::STEP_BITS'(aau_pkg::DIVX_STEPS - 1);
    localparam logic [aau_pkg::STEP_BITS-1:0] RECIP_LAST =
        aau_pkg::STEP_BITS'(aau_pkg::RECIP_STEPS - 1);
    localparam logic [aau_pkg::STEP_BITS-1:0] SDIV_LAST  =
        aau_pkg::STEP_BITS'(aau_pkg::SDIV_STEPS - 1);
    localparam logic [aau_pkg::STEP_BITS-1:0] STEP_LIMIT =
        aau_pkg::STEP_BITS'(aau_pkg::DIVX_STEPS);

    aau_pkg::state_t state_reg;
    aau_pkg::state_t state_next;
    logic [aau_pkg::STEP_BITS-1:0] cnt_reg;
    logic [aau_pkg::STEP_BITS-1:0] cnt_next;
    logic [10:0] cmd_excl;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aau_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            aau_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = aau_pkg::ST_LOAD;
                end
            end
            aau_pkg::ST_LOAD:
            begin
                cmd.prep_x = 1'b1;
                cnt_next   = '0;
                if (sts.op_start || sts.done || sts.downhill)
                begin
                    state_next = aau_pkg::ST_COMMIT;
                end
                else if (sts.k_big)
                begin
                    state_next = aau_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = aau_pkg::ST_DIVX;
                end
            end
            aau_pkg::ST_DIVX:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIVX_LAST)
                begin
                    state_next = aau_pkg::ST_TINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            aau_pkg::ST_TINIT:
            begin
                cmd.tay_init = 1'b1;
                state_next   = aau_pkg::ST_TMUL;
            end
            aau_pkg::ST_TMUL:
            begin
                cmd.tay_mul = 1'b1;
                cnt_next    = '0;
                state_next  = aau_pkg::ST_TDIV;
            end
            aau_pkg::ST_TDIV:
            begin
                cmd.sdiv_step = 1'b1;
                if (cnt_reg == SDIV_LAST)
                begin
                    cmd.sdiv_last = 1'b1;
                    state_next    = sts.term_last ? aau_pkg::ST_RPREP : aau_pkg::ST_TMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            aau_pkg::ST_RPREP:
            begin
                cmd.prep_recip = 1'b1;
                cnt_next       = '0;
                state_next     = aau_pkg::ST_RDIV;
            end
            aau_pkg::ST_RDIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == RECIP_LAST)
                begin
                    state_next = aau_pkg::ST_PLOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            aau_pkg::ST_PLOAD:
            begin
                cmd.p_load = 1'b1;
                state_next = aau_pkg::ST_SCALE;
            end
            aau_pkg::ST_SCALE:
            begin
                if (sts.k_zero)
                begin
                    state_next = aau_pkg::ST_DECIDE;
                end
                else
                begin
                    cmd.scale_step = 1'b1;
                end
            end
            aau_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = aau_pkg::ST_COMMIT;
            end
            aau_pkg::ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = aau_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aau_pkg::ST_IDLE;
            end
        endcase
    end

    // Apart from sdiv_last, which comes with the final sdiv_step, commands that load datapath registers never overlap.
    assign cmd_excl = {cmd.capture, cmd.prep_x, cmd.div_step, cmd.tay_init, cmd.tay_mul,
                       cmd.sdiv_step, cmd.prep_recip, cmd.p_load, cmd.scale_step,
                       cmd.decide, cmd.commit};

    `AAU_ASSERT(a_cmd_exclusive, $onehot0(cmd_excl), "datapath commands overlap")
    `AAU_ASSERT(a_step_bound, cnt_reg < STEP_LIMIT, "step counter beyond longest loop")
    `AAU_ASSERT(a_capture_idle, cmd.capture |=> !in_ready, "second beat taken while busy")

endmodule

// ----- rtl/core/aau_datapath.sv -----
`include "annealing_acceptance_unit_macros.svh"

module aau_datapath #(
    parameter int ERROR_BITS  = aau_pkg::ERROR_BITS_DEF,
    parameter int RANDOM_BITS = aau_pkg::RANDOM_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [aau_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [aau_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_op,
    input  logic [ERROR_BITS-1:0]              in_error,
    input  logic [RANDOM_BITS-1:0]             in_random,
    input  aau_pkg::ctrl_cmd_t                 cmd,
    output aau_pkg::ctrl_sts_t                 sts,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic                               out_accept,
    output logic                               out_new_best,
    output logic [ERROR_BITS-1:0]              out_best_error,
    output logic [ERROR_BITS-1:0]              out_temperature,
    output logic                               out_finished
);

    localparam int DIV_BITS   = (ERROR_BITS > aau_pkg::SUM_BITS) ? ERROR_BITS
                                                                 : aau_pkg::SUM_BITS;
    localparam int CMP_BITS   = aau_pkg::P_BITS + RANDOM_BITS;
    localparam int SCALE_BITS = aau_pkg::P_BITS + aau_pkg::EXP_SHIFT;
    localparam int CP_BITS    = ERROR_BITS + aau_pkg::COOL_BITS;
    localparam int PROD_BITS  = aau_pkg::TERM_BITS + aau_pkg::FRAC_BITS;
    localparam int INT_BITS   = aau_pkg::INT_BITS;
    localparam int FEED_BITS  = aau_pkg::FEED_BITS;
    localparam int FRAC_BITS  = aau_pkg::FRAC_BITS;
    localparam int NUM_BITS   = aau_pkg::NUM_BITS;
    localparam int SDIV_BITS  = aau_pkg::SDIV_BITS;
    localparam int N_BITS     = aau_pkg::N_BITS;
    localparam logic [aau_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [aau_pkg::P_BITS-1:0] P_ONE =
        aau_pkg::P_BITS'(1) << FRAC_BITS;

    // Configuration and persistent state.
    logic [ERROR_BITS-1:0]           thr_reg;
    logic [ERROR_BITS-1:0]           tstart_reg;
    logic [aau_pkg::COOL_BITS-1:0]   cool_reg;
    logic [aau_pkg::COUNT_BITS-1:0]  limit_reg;
    logic [ERROR_BITS-1:0]           last_reg,  last_next;
    logic [ERROR_BITS-1:0]           best_reg,  best_next;
    logic [ERROR_BITS-1:0]           temp_reg,  temp_next;
    logic [aau_pkg::COUNT_BITS-1:0]  count_reg, count_next;
    logic                            done_reg,  done_next;
    logic                            out_valid_reg, out_valid_next;

    // Working registers.
    logic                            op_reg;
    logic [ERROR_BITS-1:0]           err_reg;
    logic [RANDOM_BITS-1:0]          rnd_reg;
    logic [DIV_BITS-1:0]             rem_reg,  rem_next;
    logic [DIV_BITS-1:0]             den_reg,  den_next;
    logic [FEED_BITS-1:0]            feed_reg, feed_next;
    logic [aau_pkg::X_BITS-1:0]      quo_reg,  quo_next;
    logic [FRAC_BITS-1:0]            f_reg,    f_next;
    logic [INT_BITS-1:0]             k_reg,    k_next;
    logic [aau_pkg::TERM_BITS-1:0]   term_reg, term_next;
    logic [aau_pkg::SUM_BITS-1:0]    sum_reg,  sum_next;
    logic [N_BITS-1:0]               n_reg,    n_next;
    logic [NUM_BITS-1:0]             num_reg,  num_next;
    logic [NUM_BITS-1:0]             sq_reg,   sq_next;
    logic [N_BITS-1:0]               sr_reg,   sr_next;
    logic [aau_pkg::P_BITS-1:0]      p_reg,    p_next;
    logic                            up_reg,   up_next;
    logic                            acc_reg,  acc_next;
    logic                            nb_reg,   nb_next;
    logic [ERROR_BITS-1:0]           obest_reg, otemp_reg;
    logic                            ofin_reg;

    // Combinational terms.
    logic [ERROR_BITS-1:0]           diff;
    logic                            downhill;
    logic                            k_big;
    logic [DIV_BITS:0]               trial;
    logic [DIV_BITS:0]               trial_sub;
    logic                            trial_ge;
    logic [PROD_BITS-1:0]            tprod;
    logic [SDIV_BITS-1:0]            qbyte;
    logic [N_BITS-1:0]               qrem;
    logic [NUM_BITS-1:0]             term_new;
    logic [aau_pkg::RECIP_BITS-1:0]  recip_num;
    logic [SCALE_BITS-1:0]           sprod;
    logic [CMP_BITS-1:0]             cmp_lhs;
    logic [CMP_BITS-1:0]             cmp_rhs;
    logic [CP_BITS-1:0]              cool_prod;
    logic [ERROR_BITS-1:0]           cooled;
    logic [aau_pkg::COUNT_BITS-1:0]  count_inc;

    // Comparisons against the last accepted error and the temperature.
    assign diff     = err_reg - last_reg;
    assign downhill = err_reg <= last_reg;
    assign k_big    = {{INT_BITS{1'b0}}, diff} >= {temp_reg, {INT_BITS{1'b0}}};

    // One restoring step of the shared divider.
    assign trial     = {rem_reg, feed_reg[FEED_BITS-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign trial_ge  = trial >= {1'b0, den_reg};

    // Product of the current series term and the fraction.
    assign tprod = PROD_BITS'(term_reg) * PROD_BITS'(f_reg);

    // Eight bits of the series term divided by its index.
    always_comb
    begin
        logic [N_BITS:0] t;
        logic [N_BITS-1:0] r;
        r     = sr_reg;
        qbyte = '0;
        for (int i = 0; i < SDIV_BITS; i++)
        begin
            t = {r, num_reg[NUM_BITS-1-i]};
            if (t >= {1'b0, n_reg})
            begin
                t                     = t - {1'b0, n_reg};
                qbyte[SDIV_BITS-1-i]  = 1'b1;
            end
            r = t[N_BITS-1:0];
        end
        qrem = r;
    end

    assign term_new  = {sq_reg[NUM_BITS-SDIV_BITS-1:0], qbyte};
    assign recip_num = aau_pkg::RECIP_ONE +
                       aau_pkg::RECIP_BITS'(sum_reg >> 1);
    assign sprod     = SCALE_BITS'(p_reg) * SCALE_BITS'(aau_pkg::EXP_M1_Q32) +
                       SCALE_BITS'(aau_pkg::ROUND_HALF);
    assign cmp_lhs   = CMP_BITS'({rnd_reg, {FRAC_BITS{1'b0}}});
    assign cmp_rhs   = CMP_BITS'(p_reg) * CMP_BITS'({RANDOM_BITS{1'b1}});
    assign cool_prod = CP_BITS'(temp_reg) * CP_BITS'(cool_reg);
    assign cooled    = cool_prod[FRAC_BITS +: ERROR_BITS];
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // Outcome of the beat at commit time.
    always_comb
    begin
        last_next  = last_reg;
        best_next  = best_reg;
        temp_next  = temp_reg;
        count_next = count_reg;
        done_next  = done_reg;
        acc_next   = 1'b0;
        nb_next    = 1'b0;
        if (op_reg == aau_pkg::OP_START)
        begin
            last_next  = err_reg;
            best_next  = err_reg;
            temp_next  = tstart_reg;
            count_next = '0;
            done_next  = 1'b0;
            acc_next   = 1'b1;
            nb_next    = 1'b1;
        end
        else if (!done_reg)
        begin
            count_next = count_inc;
            if (downhill)
            begin
                acc_next  = 1'b1;
                last_next = err_reg;
                if (err_reg < best_reg)
                begin
                    best_next = err_reg;
                    nb_next   = 1'b1;
                end
            end
            else if (up_reg)
            begin
                acc_next  = 1'b1;
                last_next = err_reg;
                temp_next = cooled;
            end
            done_next = (count_inc >= limit_reg) || (best_next < thr_reg);
        end
    end

    // Working register updates.
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        feed_next = feed_reg;
        quo_next  = quo_reg;
        f_next    = f_reg;
        k_next    = k_reg;
        term_next = term_reg;
        sum_next  = sum_reg;
        n_next    = n_reg;
        num_next  = num_reg;
        sq_next   = sq_reg;
        sr_next   = sr_reg;
        p_next    = p_reg;
        up_next   = up_reg;
        if (cmd.prep_x)
        begin
            rem_next  = DIV_BITS'(diff >> INT_BITS);
            feed_next = {diff[INT_BITS-1:0], {(FEED_BITS-INT_BITS){1'b0}}};
            den_next  = DIV_BITS'(temp_reg);
            quo_next  = '0;
            p_next    = '0;
        end
        if (cmd.div_step)
        begin
            rem_next  = trial_ge ? trial_sub[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
            quo_next  = {quo_reg[aau_pkg::X_BITS-2:0], trial_ge};
            feed_next = {feed_reg[FEED_BITS-2:0], 1'b0};
        end
        if (cmd.tay_init)
        begin
            f_next    = quo_reg[FRAC_BITS-1:0];
            k_next    = quo_reg[aau_pkg::X_BITS-1:FRAC_BITS];
            term_next = aau_pkg::TERM_ONE;
            sum_next  = aau_pkg::SUM_BITS'(aau_pkg::TERM_ONE);
            n_next    = N_BITS'(1);
        end
        if (cmd.tay_mul)
        begin
            num_next = tprod[FRAC_BITS +: NUM_BITS];
            sq_next  = '0;
            sr_next  = '0;
        end
        if (cmd.sdiv_step)
        begin
            num_next = num_reg << SDIV_BITS;
            sq_next  = term_new;
            sr_next  = qrem;
        end
        if (cmd.sdiv_last)
        begin
            term_next = aau_pkg::TERM_BITS'(term_new);
            sum_next  = sum_reg + aau_pkg::SUM_BITS'(term_new);
            n_next    = n_reg + 1'b1;
        end
        if (cmd.prep_recip)
        begin
            rem_next  = DIV_BITS'(recip_num[aau_pkg::RECIP_BITS-1:FEED_BITS]);
            feed_next = recip_num[FEED_BITS-1:0];
            den_next  = DIV_BITS'(sum_reg);
            quo_next  = '0;
        end
        if (cmd.p_load)
        begin
            p_next = quo_reg[aau_pkg::P_BITS-1:0];
        end
        if (cmd.scale_step)
        begin
            p_next = sprod[SCALE_BITS-1:aau_pkg::EXP_SHIFT];
            k_next = k_reg - 1'b1;
        end
        if (cmd.decide)
        begin
            up_next = cmp_lhs <= cmp_rhs;
        end
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration, persistent state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= ERROR_BITS'(aau_pkg::THRESHOLD_RESET);
            tstart_reg    <= ERROR_BITS'(aau_pkg::TSTART_RESET);
            cool_reg      <= aau_pkg::COOL_RESET;
            limit_reg     <= aau_pkg::LIMIT_RESET;
            last_reg      <= '0;
            best_reg      <= '1;
            temp_reg      <= ERROR_BITS'(aau_pkg::TSTART_RESET);
            count_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    aau_pkg::CFG_BREAK_THRESHOLD:   thr_reg    <= ERROR_BITS'(cfg_data);
                    aau_pkg::CFG_START_TEMPERATURE: tstart_reg <= ERROR_BITS'(cfg_data);
                    aau_pkg::CFG_COOLING_FACTOR:
                        cool_reg  <= cfg_data[aau_pkg::COOL_BITS-1:0];
                    aau_pkg::CFG_ITERATION_LIMIT:
                        limit_reg <= cfg_data[aau_pkg::COUNT_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit)
            begin
                last_reg  <= last_next;
                best_reg  <= best_next;
                temp_reg  <= temp_next;
                count_reg <= count_next;
                done_reg  <= done_next;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            err_reg <= in_error;
            rnd_reg <= in_random;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        feed_reg <= feed_next;
        quo_reg  <= quo_next;
        f_reg    <= f_next;
        k_reg    <= k_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        n_reg    <= n_next;
        num_reg  <= num_next;
        sq_reg   <= sq_next;
        sr_reg   <= sr_next;
        p_reg    <= p_next;
        up_reg   <= up_next;
        if (cmd.commit)
        begin
            acc_reg   <= acc_next;
            nb_reg    <= nb_next;
            obest_reg <= best_next;
            otemp_reg <= temp_next;
            ofin_reg  <= done_next;
        end
    end

    // Status to the controller.
    assign sts.op_start  = op_reg == aau_pkg::OP_START;
    assign sts.done      = done_reg;
    assign sts.downhill  = downhill;
    assign sts.k_big     = k_big;
    assign sts.term_last = n_reg == aau_pkg::TAYLOR_TERMS;
    assign sts.k_zero    = k_reg == '0;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_accept      = acc_reg;
    assign out_new_best    = nb_reg;
    assign out_best_error  = obest_reg;
    assign out_temperature = otemp_reg;
    assign out_finished    = ofin_reg;

    `AAU_ASSERT(a_rem_bound, $past(cmd.div_step) |-> (rem_reg < den_reg),
        "divider remainder not below divisor")
    `AAU_ASSERT(a_p_bound, $past(cmd.p_load) |-> (p_reg <= P_ONE),
        "probability above one after reciprocal")
    `AAU_NEVER(a_commit_busy, cmd.commit && out_valid_reg && !out_ready,
        "result overwritten before it was taken")

endmodule

// ----- rtl/core/annealing_acceptance_unit.sv -----
// Channel   Direction  Signals                       Content
// s_axis    in         s_tvalid s_tready s_tdata     error_value, random_fraction
//                      s_tuser                       op
// m_axis    out        m_tvalid m_tready m_tdata     accept, new_best, best_error,
//                                                    temperature, finished
// cfg       in         cfg_we cfg_index cfg_data     four configuration registers
//
// A start beat, a candidate after finishing and a candidate that is not worse go from
// the load state straight to commit, a worse one with vanishing probability through the
// decision state first, and the full path (k up to 15, the integer part of diff/T) runs
// 20 divider steps for diff/T, 12 series terms, 17 reciprocal steps and k exp(-1) rounds.
// Reset clears state and configuration at once; no clearing pass is needed.
// A new beat is accepted while a result waits; its own result stalls until that one goes.

module annealing_acceptance_unit #(
    parameter int ERROR_BITS     = aau_pkg::ERROR_BITS_DEF,
    parameter int RANDOM_BITS    = aau_pkg::RANDOM_BITS_DEF,
    localparam int IN_DATA_BITS  = ((ERROR_BITS + RANDOM_BITS + 7) / 8) * 8,
    localparam int OUT_FIELDS    = 2 * ERROR_BITS + 3,
    localparam int OUT_DATA_BITS = ((OUT_FIELDS + 7) / 8) * 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [aau_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [aau_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // error_value, random_fraction
    input  logic [IN_DATA_BITS-1:0]            s_tdata,
    // op
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // accept, new_best, best_error, temperature, finished
    output logic [OUT_DATA_BITS-1:0]           m_tdata
);

    aau_pkg::ctrl_cmd_t cmd;
    aau_pkg::ctrl_sts_t sts;
    logic                  res_accept;
    logic                  res_new_best;
    logic [ERROR_BITS-1:0] res_best_error;
    logic [ERROR_BITS-1:0] res_temperature;
    logic                  res_finished;

    // Sequencer.
    aau_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic, state and output register.
    aau_datapath #(
        .ERROR_BITS  (ERROR_BITS),
        .RANDOM_BITS (RANDOM_BITS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_op           (s_tuser[0]),
        .in_error        (s_tdata[ERROR_BITS-1:0]),
        .in_random       (s_tdata[ERROR_BITS +: RANDOM_BITS]),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_accept      (res_accept),
        .out_new_best    (res_new_best),
        .out_best_error  (res_best_error),
        .out_temperature (res_temperature),
        .out_finished    (res_finished)
    );

    // Pack the result beat, first field lowest.
    assign m_tdata = OUT_DATA_BITS'({res_finished, res_temperature, res_best_error,
                                     res_new_best, res_accept});

endmodule

// ----- sim/tb_annealing_acceptance_unit.sv -----
module tb_annealing_acceptance_unit;

    // Widths of the packed beats: error_value and random_fraction in, five result fields out.
    localparam int IN_W        = 48;
    localparam int OUT_W       = 72;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_PCT    = 37;
    localparam int PHASE_BEATS = 50;
    localparam int N_DIRECTED  = 15;

    typedef struct packed {
        logic        accept;
        logic        new_best;
        logic [31:0] best_error;
        logic [31:0] temperature;
        logic        finished;
    } verdict_t;

    typedef struct packed {
        logic        op;
        logic [31:0] err;
        logic [15:0] frac;
        logic        typed;
        verdict_t    want;
    } stim_row_t;

    // Directed beats, walked from the reset configuration. Rows with typed set carry
    // their expected verdict; the rest are left to the predictor.
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // Candidate before any start works on the reset state and drops below threshold.
        '{aau_pkg::OP_CANDIDATE, 32'h0000_0000, 16'h0000, 1'b1,
          '{1'b1, 1'b1, 32'h0000_0000, 32'h0001_0000, 1'b1}},
        // Candidate after finishing is ignored.
        '{aau_pkg::OP_CANDIDATE, 32'h0000_0005, 16'h0007, 1'b1,
          '{1'b0, 1'b0, 32'h0000_0000, 32'h0001_0000, 1'b1}},
        '{aau_pkg::OP_START, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          '{1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0}},
        // Equal error counts as not worse, but is no new best.
        '{aau_pkg::OP_CANDIDATE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0}},
        '{aau_pkg::OP_START, 32'h0010_0000, 16'h0000, 1'b1,
          '{1'b1, 1'b1, 32'h0010_0000, 32'h0001_0000, 1'b0}},
        // Uphill by one temperature: rejected at one half, taken at zero.
        '{aau_pkg::OP_CANDIDATE, 32'h0011_0000, 16'h8000, 1'b0, '0},
        '{aau_pkg::OP_CANDIDATE, 32'h0011_0000, 16'h0000, 1'b0, '0},
        // Uphill by sixteen temperatures: probability vanishes, only zero passes.
        '{aau_pkg::OP_CANDIDATE, 32'h0021_0000, 16'h0001, 1'b0, '0},
        '{aau_pkg::OP_CANDIDATE, 32'h0021_0000, 16'h0000, 1'b0, '0},
        '{aau_pkg::OP_CANDIDATE, 32'h0021_8000, 16'hFFFF, 1'b0, '0},
        '{aau_pkg::OP_CANDIDATE, 32'h0000_0800, 16'h1234, 1'b0, '0},
        '{aau_pkg::OP_CANDIDATE, 32'h0000_0100, 16'hFFFF, 1'b0, '0},
        '{aau_pkg::OP_CANDIDATE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        // A start clears finishing even with the best below threshold.
        '{aau_pkg::OP_START, 32'h0000_0000, 16'hFFFF, 1'b1,
          '{1'b1, 1'b1, 32'h0000_0000, 32'h0001_0000, 1'b0}},
        '{aau_pkg::OP_CANDIDATE, 32'h0000_0000, 16'h0000, 1'b1,
          '{1'b1, 1'b0, 32'h0000_0000, 32'h0001_0000, 1'b1}}
    };

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [aau_pkg::CFG_INDEX_BITS-1:0] cfg_index = aau_pkg::CFG_BREAK_THRESHOLD;
    logic [aau_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    // error_value, random_fraction
    logic [IN_W-1:0]                    s_tdata   = '0;
    // op
    logic [0:0]                         s_tuser   = aau_pkg::OP_START;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    // accept, new_best, best_error, temperature, finished
    logic [OUT_W-1:0]                   m_tdata;

    // Shadow of the configuration registers.
    logic [31:0] thresh_cfg = aau_pkg::THRESHOLD_RESET;
    logic [31:0] tstart_cfg = aau_pkg::TSTART_RESET;
    logic [15:0] cool_cfg   = aau_pkg::COOL_RESET;
    logic [15:0] limit_cfg  = aau_pkg::LIMIT_RESET;

    // Shadow of the annealing state.
    logic [31:0] last_err = '0;
    logic [31:0] best_err = '1;
    logic [31:0] temp_q   = aau_pkg::TSTART_RESET;
    logic [15:0] iter_cnt = '0;
    logic        done_q   = 1'b0;

    verdict_t pending_verdicts [$];
    int       fail_count  = 0;
    int       cycle_count = 0;
    bit       steady      = 1'b0;

    annealing_acceptance_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Sixteen fraction bits of rem / den by restoring division, rem below den.
    function automatic logic [15:0] frac_bits(logic [63:0] rem, logic [63:0] den);
        logic [15:0] q;
        q = '0;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den)
            begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-diff/t) in Q1.16: Taylor sum of exp(frac) in Q32, its reciprocal, then
    // one exp(-1) rounding step for each whole unit of diff/t.
    function automatic logic [63:0] metropolis_prob(logic [63:0] diff, logic [63:0] t);
        logic [63:0] whole, f, term, sum, p;
        if (t == 0)
            return 64'd0;
        whole = diff / t;
        if (whole >= 16)
            return 64'd0;
        f    = 64'(frac_bits(diff % t, t));
        term = 64'd1 << 32;
        sum  = term;
        for (int n = 1; n <= 12; n++)
        begin
            term = (term * f) / (64'(n) << 16);
            sum  = sum + term;
        end
        p = ((64'd1 << 48) + (sum >> 1)) / sum;
        for (int j = 0; j < int'(whole); j++)
            p = (p * 64'(aau_pkg::EXP_M1_Q32) + (64'd1 << 31)) >> 32;
        return p;
    endfunction

    function automatic logic [31:0] cooled_temp(logic [31:0] t, logic [15:0] c);
        logic [63:0] prod;
        prod = 64'(t >> 16) * 64'(c) + ((64'(t[15:0]) * 64'(c)) >> 16);
        return prod[31:0];
    endfunction

    // Advances the shadow state by one beat and returns the verdict it yields.
    function automatic verdict_t predict_verdict(logic op, logic [31:0] err, logic [15:0] frac);
        verdict_t    v;
        logic [63:0] p;
        v = '0;
        if (op == aau_pkg::OP_START)
        begin
            last_err   = err;
            best_err   = err;
            temp_q     = tstart_cfg;
            iter_cnt   = '0;
            done_q     = 1'b0;
            v.accept   = 1'b1;
            v.new_best = 1'b1;
        end
        else if (!done_q)
        begin
            if (iter_cnt != 16'hFFFF)
                iter_cnt = iter_cnt + 16'd1;
            if (err <= last_err)
            begin
                v.accept = 1'b1;
                last_err = err;
                if (err < best_err)
                begin
                    best_err   = err;
                    v.new_best = 1'b1;
                end
            end
            else
            begin
                p = metropolis_prob(64'(err - last_err), 64'(temp_q));
                if ((64'(frac) << 16) <= p * 64'd65535)
                begin
                    v.accept = 1'b1;
                    last_err = err;
                    temp_q   = cooled_temp(temp_q, cool_cfg);
                end
            end
            if (iter_cnt >= limit_cfg || best_err < thresh_cfg)
                done_q = 1'b1;
        end
        v.best_error  = best_err;
        v.temperature = temp_q;
        v.finished    = done_q;
        return v;
    endfunction

    // Candidate errors mostly stay within a few temperatures of the last accepted
    // error, so that uphill moves have a real chance of acceptance.
    function automatic logic [31:0] pick_candidate();
        logic [63:0] span, delta, e;
        int          mode;
        mode = $urandom_range(0, 9);
        span = (temp_q == 0) ? 64'h1_0000 : 64'(temp_q);
        if (mode == 0)
            return $urandom;
        if (mode <= 3)
        begin
            delta = (span * $urandom_range(0, 48)) >> 4;
            if (delta >= 64'(last_err))
                return $urandom_range(0, last_err);
            return last_err - delta[31:0];
        end
        delta = ((span * $urandom_range(0, 288)) >> 4) + 64'($urandom_range(0, 1));
        e = 64'(last_err) + delta;
        return (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
    endfunction

    function automatic logic [15:0] pick_fraction();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'h0000;
        if (pick == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Drives one beat, waits for its handshake and records the expected verdict.
    task automatic send_beat(logic op, logic [31:0] err, logic [15:0] frac,
                             logic typed, verdict_t want);
        verdict_t v;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {frac, err};
        do
            @(posedge clk);
        while (!s_tready);
        v = predict_verdict(op, err, frac);
        pending_verdicts.push_back(typed ? want : v);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(aau_pkg::cfg_index_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            aau_pkg::CFG_BREAK_THRESHOLD:   thresh_cfg = value;
            aau_pkg::CFG_START_TEMPERATURE: tstart_cfg = value;
            aau_pkg::CFG_COOLING_FACTOR:    cool_cfg   = value[15:0];
            aau_pkg::CFG_ITERATION_LIMIT:   limit_cfg  = value[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_regs(logic [31:0] th, logic [31:0] ts, logic [15:0] cf,
                                logic [15:0] lim);
        put_reg(aau_pkg::CFG_BREAK_THRESHOLD, th);
        put_reg(aau_pkg::CFG_START_TEMPERATURE, ts);
        put_reg(aau_pkg::CFG_COOLING_FACTOR, 32'(cf));
        put_reg(aau_pkg::CFG_ITERATION_LIMIT, 32'(lim));
        cfg_we <= 1'b0;
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: random back-pressure and comparison against the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result beat with no expected verdict: 0x%018h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                compare_field("accept", 32'(want.accept), 32'(m_tdata[0]));
                compare_field("new_best", 32'(want.new_best), 32'(m_tdata[1]));
                compare_field("best_error", want.best_error, m_tdata[33:2]);
                compare_field("temperature", want.temperature, m_tdata[65:34]);
                compare_field("finished", 32'(want.finished), 32'(m_tdata[66]));
            end
        end
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("annealing_acceptance_unit test failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] th;
        logic [31:0] ts;
        logic [15:0] cf;
        logic [15:0] lim;
        int          counted;
        int          run_len;
        logic        op;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats against the reset configuration.
        for (int r = 0; r < N_DIRECTED; r++)
            send_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].err, DIRECTED_ROWS[r].frac,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        wait_idle();

        // Random phases, each under its own register setting.
        for (int ph = 1; ph <= 9; ph++)
        begin
            case (ph)
                1:       program_regs(32'h0, 32'h1, 16'h1, 16'h1);
                2:       program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
                3:       program_regs(32'h0, 32'h0, 16'h0, 16'h0);
                default:
                begin
                    th  = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, 32'h2_0000);
                    ts  = ($urandom_range(0, 2) == 0) ? $urandom
                                                      : $urandom_range(32'h1000, 32'h8_0000);
                    cf  = 16'($urandom_range(16'h8000, 16'hFFFF));
                    lim = 16'($urandom_range(3, 40));
                    program_regs(th, ts, cf, lim);
                end
            endcase
            steady  = (ph == 5);
            counted = 0;
            while (counted < PHASE_BEATS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise beat with fully random content.
                    op = 1'($urandom_range(0, 1));
                    counted++;
                    send_beat(op, $urandom, 16'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
                end
                else
                begin
                    // A start followed by a run of candidates near the last accepted error.
                    send_beat(aau_pkg::OP_START, ($urandom_range(0, 1) == 0) ? $urandom
                              : $urandom_range(32'h100, 32'h00FF_FFFF), pick_fraction(),
                              1'b0, '0);
                    counted++;
                    run_len = $urandom_range(3, 20);
                    for (int c = 0; c < run_len; c++)
                    begin
                        if (counted >= PHASE_BEATS || (done_q && $urandom_range(0, 2) != 0))
                            break;
                        counted++;
                        send_beat(aau_pkg::OP_CANDIDATE, pick_candidate(), pick_fraction(),
                                  1'b0, '0);
                    end
                end
            end
            wait_idle();
        end
        steady = 1'b0;

        // Let any stray result show itself before the verdict.
        repeat (150) @(posedge clk);
        if (fail_count == 0)
            $display("annealing_acceptance_unit test passed");
        else
            $display("annealing_acceptance_unit test failed");
        $finish;
    end

endmodule
